// ===== rtl/pstq_pkg.sv =====
// ----------------------------------------------------------------------------
// PPS strike timestamp qualifier package
// Shared widths, codes, constants and the divider request and response types.
// ----------------------------------------------------------------------------
package pstq_pkg;

    localparam int RING_DEPTH     = 20;
    localparam int SMOOTH_DIVISOR = 3600;
    localparam int PTR_W          = $clog2(RING_DEPTH);
    localparam int FRAC_BITS      = 16;

    localparam int COUNT_W   = 24;
    localparam int DIF_W     = 25;
    localparam int SEC_W     = 6;
    localparam int LAT_W     = 28;
    localparam int LON_W     = 29;
    localparam int ALT_W     = 21;
    localparam int WALL_W    = 32;
    localparam int NS_W      = 30;
    localparam int BUSY_W    = 8;
    localparam int ISUM_W    = 30;
    localparam int LAT_SUM_W = 33;
    localparam int LON_SUM_W = 34;
    localparam int ALT_SUM_W = 26;
    localparam int SMOOTH_W  = 46;
    localparam int DIV_W     = 64;
    localparam int DVR_W     = 32;
    localparam int MUL_B_W   = 25;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int SPS_W      = 8;
    localparam int PPM_W      = 10;
    localparam int TOL_W      = 20;
    localparam int HB_W       = 17;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_STRIKE = 1'b1;

    localparam logic KIND_HEARTBEAT = 1'b0;
    localparam logic KIND_STRIKE    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BUSY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_TOL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_TOL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT = 3'd4;

    localparam logic [SPS_W-1:0]  RST_MAX_SPS   = 8'd12;
    localparam logic [SPS_W-1:0]  RST_MAX_BUSY  = 8'd6;
    localparam logic [PPM_W-1:0]  RST_TIME_TOL  = 10'd1;
    localparam logic [TOL_W-1:0]  RST_POS_TOL   = 20'd1000;
    localparam logic [HB_W-1:0]   RST_HEARTBEAT = 17'd600;

    localparam logic [DIV_W-1:0] NS_SCALE  = 64'(RING_DEPTH) * 64'd1000000000;
    localparam logic [NS_W-1:0]  NS_MAX    = 30'd999999999;
    localparam logic [49:0]      PPM_SCALE = 50'd1000000;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/pstq_channels.sv =====
// ----------------------------------------------------------------------------
// PPS strike timestamp qualifier channels
// Valid/ready channels for input items, reports and register writes.
// ----------------------------------------------------------------------------
interface pstq_item_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  cmd;
    logic        [pstq_pkg::COUNT_W-1:0]   counter;
    logic        [pstq_pkg::SEC_W-1:0]     second;
    logic signed [pstq_pkg::LAT_W-1:0]     latitude;
    logic signed [pstq_pkg::LON_W-1:0]     longitude;
    logic signed [pstq_pkg::ALT_W-1:0]     altitude;
    logic        [pstq_pkg::WALL_W-1:0]    wall_seconds;

    modport source (output valid, cmd, counter, second, latitude, longitude, altitude,
                    wall_seconds, input ready);
    modport sink   (input valid, cmd, counter, second, latitude, longitude, altitude,
                    wall_seconds, output ready);
endinterface

interface pstq_report_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  report_kind;
    logic        [pstq_pkg::NS_W-1:0]      strike_nsec;
    logic        [pstq_pkg::SEC_W-1:0]     report_second;
    logic signed [pstq_pkg::LAT_W-1:0]     smooth_latitude;
    logic signed [pstq_pkg::LON_W-1:0]     smooth_longitude;
    logic signed [pstq_pkg::ALT_W-1:0]     smooth_altitude;
    logic        [pstq_pkg::BUSY_W-1:0]    busy_seconds_out;

    modport source (output valid, report_kind, strike_nsec, report_second, smooth_latitude,
                    smooth_longitude, smooth_altitude, busy_seconds_out, input ready);
    modport sink   (input valid, report_kind, strike_nsec, report_second, smooth_latitude,
                    smooth_longitude, smooth_altitude, busy_seconds_out, output ready);
endinterface

interface pstq_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pstq_pkg::CFG_IDX_W-1:0]      index;
    logic [pstq_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/pstq_serial_div.sv =====
// ----------------------------------------------------------------------------
// PPS strike timestamp qualifier serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pstq_serial_div (
    input  logic               clk,
    input  logic               rst_n,
    input  pstq_pkg::div_req_t req,
    output pstq_pkg::div_rsp_t rsp
);

    localparam int STEP_W = $clog2(pstq_pkg::DIV_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [pstq_pkg::DVR_W-1:0]    rem_reg, rem_next;
    logic [pstq_pkg::DVR_W-1:0]    dvr_reg, dvr_next;
    logic [pstq_pkg::DIV_W-1:0]    quo_reg, quo_next;

    logic [pstq_pkg::DVR_W:0]      shifted;
    logic [pstq_pkg::DVR_W:0]      diff;
    logic                          fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[pstq_pkg::DIV_W-1]};
        diff    = shifted - {1'b0, dvr_reg};
        fits    = (shifted >= {1'b0, dvr_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvr_next  = dvr_reg;
        quo_next  = quo_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvr_next  = req.divisor;
            quo_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[pstq_pkg::DVR_W-1:0] : shifted[pstq_pkg::DVR_W-1:0];
            quo_next  = {quo_reg[pstq_pkg::DIV_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(pstq_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvr_reg <= dvr_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/pps_strike_timestamp_qualifier_core.sv =====
// ----------------------------------------------------------------------------
// PPS strike timestamp qualifier core
// Qualifies strike timestamps against a ring of once-per-second GPS records.
// ----------------------------------------------------------------------------
// The block takes one request at a time. A strike that is not reported is only
// counted; a reported strike runs a shift-add multiply over the bits of the
// counter difference followed by the serial divider. A GPS record runs the sum,
// deviation and flag updates, then for each of latitude, longitude and altitude
// one division for the ring average, a shift-add multiply and a second division
// for the smoothing (when the position has just become qualified, the average is
// taken as it is), then the heartbeat check. A result waits in an output
// register, and the next request is taken while it waits. The first GPS record
// only latches the counter. Registers may be written at any time the block is idle.
module pps_strike_timestamp_qualifier_core (
    input  logic          clk,
    input  logic          rst_n,
    pstq_item_if.sink     item,
    pstq_report_if.source report,
    pstq_cfg_if.sink      cfg
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_S_MUL   = 4'd1;
    localparam logic [3:0] ST_S_DIV   = 4'd2;
    localparam logic [3:0] ST_EMIT    = 4'd3;
    localparam logic [3:0] ST_R_SUM   = 4'd4;
    localparam logic [3:0] ST_R_DEV   = 4'd5;
    localparam logic [3:0] ST_R_FLAG  = 4'd6;
    localparam logic [3:0] ST_A_START = 4'd7;
    localparam logic [3:0] ST_A_DIV   = 4'd8;
    localparam logic [3:0] ST_M_MUL   = 4'd9;
    localparam logic [3:0] ST_M_DIV   = 4'd10;
    localparam logic [3:0] ST_HB      = 4'd11;

    localparam int DEV_W    = pstq_pkg::ISUM_W;
    localparam int PDIFF_W  = 36;
    localparam int PDEV_W   = 37;
    localparam logic signed [PDIFF_W-1:0] N_S = PDIFF_W'(pstq_pkg::RING_DEPTH);

    // Configuration.
    logic [pstq_pkg::SPS_W-1:0]  max_sps_reg, max_sps_next;
    logic [pstq_pkg::SPS_W-1:0]  max_busy_reg, max_busy_next;
    logic [pstq_pkg::PPM_W-1:0]  time_tol_reg, time_tol_next;
    logic [pstq_pkg::TOL_W-1:0]  pos_tol_reg, pos_tol_next;
    logic [pstq_pkg::HB_W-1:0]   hb_reg, hb_next;

    // Control state.
    logic [3:0]                          state_reg, state_next;
    logic                                primed_reg, primed_next;
    logic [pstq_pkg::COUNT_W-1:0]        prev_counter_reg, prev_counter_next;
    logic [pstq_pkg::SEC_W-1:0]          prev_second_reg, prev_second_next;
    logic [pstq_pkg::DIF_W-1:0]          iv_ring_reg  [pstq_pkg::RING_DEPTH];
    logic [pstq_pkg::DIF_W-1:0]          iv_ring_next [pstq_pkg::RING_DEPTH];
    logic signed [pstq_pkg::LAT_W-1:0]   lat_ring_reg  [pstq_pkg::RING_DEPTH];
    logic signed [pstq_pkg::LAT_W-1:0]   lat_ring_next [pstq_pkg::RING_DEPTH];
    logic signed [pstq_pkg::LON_W-1:0]   lon_ring_reg  [pstq_pkg::RING_DEPTH];
    logic signed [pstq_pkg::LON_W-1:0]   lon_ring_next [pstq_pkg::RING_DEPTH];
    logic signed [pstq_pkg::ALT_W-1:0]   alt_ring_reg  [pstq_pkg::RING_DEPTH];
    logic signed [pstq_pkg::ALT_W-1:0]   alt_ring_next [pstq_pkg::RING_DEPTH];
    logic [pstq_pkg::PTR_W-1:0]          ptr_reg, ptr_next;
    logic [pstq_pkg::ISUM_W-1:0]         isum_reg, isum_next;
    logic signed [pstq_pkg::LAT_SUM_W-1:0] lat_sum_reg, lat_sum_next;
    logic signed [pstq_pkg::LON_SUM_W-1:0] lon_sum_reg, lon_sum_next;
    logic signed [pstq_pkg::ALT_SUM_W-1:0] alt_sum_reg, alt_sum_next;
    logic                                sec_ok_reg, sec_ok_next;
    logic                                acc_ok_reg, acc_ok_next;
    logic                                pos_ok_reg, pos_ok_next;
    logic                                imode_reg, imode_next;
    logic [pstq_pkg::BUSY_W-1:0]         strikes_reg, strikes_next;
    logic [pstq_pkg::BUSY_W-1:0]         busy_reg, busy_next;
    logic signed [pstq_pkg::SMOOTH_W-1:0] smooth_reg  [3];
    logic signed [pstq_pkg::SMOOTH_W-1:0] smooth_next [3];
    logic [pstq_pkg::WALL_W-1:0]         last_report_reg, last_report_next;
    logic [pstq_pkg::WALL_W-1:0]         last_wall_reg, last_wall_next;
    logic                                out_valid_reg, out_valid_next;
    logic [1:0]                          axis_reg, axis_next;

    // Working registers.
    logic [pstq_pkg::DIF_W-1:0]          dif_reg, dif_next;
    logic [pstq_pkg::SEC_W-1:0]          sec_in_reg, sec_in_next;
    logic signed [pstq_pkg::LAT_W-1:0]   lat_in_reg, lat_in_next;
    logic signed [pstq_pkg::LON_W-1:0]   lon_in_reg, lon_in_next;
    logic signed [pstq_pkg::ALT_W-1:0]   alt_in_reg, alt_in_next;
    logic [pstq_pkg::WALL_W-1:0]         wall_in_reg, wall_in_next;
    logic                                was_pos_ok_reg, was_pos_ok_next;
    logic [DEV_W-1:0]                    dev_reg, dev_next;
    logic [PDEV_W-1:0]                   pdev_reg, pdev_next;
    logic [pstq_pkg::DIV_W-1:0]          mul_a_reg, mul_a_next;
    logic [pstq_pkg::MUL_B_W-1:0]        mul_b_reg, mul_b_next;
    logic [pstq_pkg::DIV_W-1:0]          acc_reg, acc_next;
    logic                                neg_reg, neg_next;
    logic [pstq_pkg::NS_W-1:0]           ns_reg, ns_next;
    logic                                kind_reg, kind_next;

    // Output payload.
    logic                                o_kind_reg, o_kind_next;
    logic [pstq_pkg::NS_W-1:0]           o_ns_reg, o_ns_next;
    logic [pstq_pkg::SEC_W-1:0]          o_sec_reg, o_sec_next;
    logic signed [pstq_pkg::LAT_W-1:0]   o_lat_reg, o_lat_next;
    logic signed [pstq_pkg::LON_W-1:0]   o_lon_reg, o_lon_next;
    logic signed [pstq_pkg::ALT_W-1:0]   o_alt_reg, o_alt_next;
    logic [pstq_pkg::BUSY_W-1:0]         o_busy_reg, o_busy_next;

    pstq_pkg::div_req_t div_req;
    pstq_pkg::div_rsp_t div_rsp;

    // Combinational helpers.
    logic [pstq_pkg::DIF_W-1:0]          dif_val;
    logic [6:0]                          sec_plus;
    logic [pstq_pkg::SEC_W-1:0]          sec_expect;
    logic [pstq_pkg::ISUM_W-1:0]         twenty_dif;
    logic signed [pstq_pkg::ISUM_W:0]    dev_s;
    logic signed [PDIFF_W-1:0]           lat_d, lon_d;
    logic [PDIFF_W-1:0]                  lat_abs, lon_abs;
    logic [49:0]                         dev_scaled, tol_scaled;
    logic [pstq_pkg::BUSY_W-1:0]         busy_inc;
    logic signed [pstq_pkg::LON_SUM_W-1:0] sum_ax;
    logic [pstq_pkg::DIV_W-1:0]          x_val;
    logic [pstq_pkg::DIV_W-1:0]          q_signed;
    logic signed [pstq_pkg::SMOOTH_W-1:0] avg_val;
    logic                                report_ok;

    function automatic logic signed [30:0] round_frac(input logic signed [45:0] s);
        logic signed [46:0] t;
        t = 47'(s) + 47'sd32768;
        return t[46:16];
    endfunction

    function automatic logic signed [30:0] clip(input logic signed [30:0] v,
                                                input int unsigned w);
        logic signed [30:0] hi;
        logic signed [30:0] lo;
        hi = (31'sd1 <<< (w - 1)) - 31'sd1;
        lo = -hi - 31'sd1;
        if (v > hi)
            return hi;
        else if (v < lo)
            return lo;
        return v;
    endfunction

    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    assign report.valid            = out_valid_reg;
    assign report.report_kind      = o_kind_reg;
    assign report.strike_nsec      = o_ns_reg;
    assign report.report_second    = o_sec_reg;
    assign report.smooth_latitude  = o_lat_reg;
    assign report.smooth_longitude = o_lon_reg;
    assign report.smooth_altitude  = o_alt_reg;
    assign report.busy_seconds_out = o_busy_reg;

    always_comb
    begin
        dif_val = (item.counter > prev_counter_reg)
                ? {1'b0, item.counter} - {1'b0, prev_counter_reg}
                : {1'b1, item.counter} - {1'b0, prev_counter_reg};

        sec_plus   = {1'b0, prev_second_reg} + 7'd1;
        sec_expect = (sec_plus >= 7'd60) ? 6'(sec_plus - 7'd60) : sec_plus[5:0];

        twenty_dif = pstq_pkg::ISUM_W'(dif_reg) * pstq_pkg::ISUM_W'(pstq_pkg::RING_DEPTH);
        dev_s      = $signed({1'b0, isum_reg}) - $signed({1'b0, twenty_dif});
        lat_d      = PDIFF_W'(lat_sum_reg) - PDIFF_W'(lat_in_reg) * N_S;
        lon_d      = PDIFF_W'(lon_sum_reg) - PDIFF_W'(lon_in_reg) * N_S;
        lat_abs    = (lat_d < 0) ? PDIFF_W'(-lat_d) : PDIFF_W'(lat_d);
        lon_abs    = (lon_d < 0) ? PDIFF_W'(-lon_d) : PDIFF_W'(lon_d);

        dev_scaled = 50'(dev_reg) * pstq_pkg::PPM_SCALE;
        tol_scaled = 50'(time_tol_reg) * 50'(isum_reg);

        busy_inc = ((strikes_reg != '0) && (busy_reg != '1)) ? busy_reg + 1'b1 : busy_reg;

        unique case (axis_reg)
            2'd0:    sum_ax = pstq_pkg::LON_SUM_W'(lat_sum_reg);
            2'd1:    sum_ax = lon_sum_reg;
            default: sum_ax = pstq_pkg::LON_SUM_W'(alt_sum_reg);
        endcase

        q_signed = neg_reg ? -div_rsp.quotient : div_rsp.quotient;
        avg_val  = q_signed[pstq_pkg::SMOOTH_W-1:0];
        x_val    = '0;

        report_ok = acc_ok_reg && pos_ok_reg && sec_ok_reg;

        max_sps_next  = max_sps_reg;
        max_busy_next = max_busy_reg;
        time_tol_next = time_tol_reg;
        pos_tol_next  = pos_tol_reg;
        hb_next       = hb_reg;

        state_next        = state_reg;
        primed_next       = primed_reg;
        prev_counter_next = prev_counter_reg;
        prev_second_next  = prev_second_reg;
        iv_ring_next      = iv_ring_reg;
        lat_ring_next     = lat_ring_reg;
        lon_ring_next     = lon_ring_reg;
        alt_ring_next     = alt_ring_reg;
        ptr_next          = ptr_reg;
        isum_next         = isum_reg;
        lat_sum_next      = lat_sum_reg;
        lon_sum_next      = lon_sum_reg;
        alt_sum_next      = alt_sum_reg;
        sec_ok_next       = sec_ok_reg;
        acc_ok_next       = acc_ok_reg;
        pos_ok_next       = pos_ok_reg;
        imode_next        = imode_reg;
        strikes_next      = strikes_reg;
        busy_next         = busy_reg;
        smooth_next       = smooth_reg;
        last_report_next  = last_report_reg;
        last_wall_next    = last_wall_reg;
        out_valid_next    = out_valid_reg && !report.ready;
        axis_next         = axis_reg;

        dif_next        = dif_reg;
        sec_in_next     = sec_in_reg;
        lat_in_next     = lat_in_reg;
        lon_in_next     = lon_in_reg;
        alt_in_next     = alt_in_reg;
        wall_in_next    = wall_in_reg;
        was_pos_ok_next = was_pos_ok_reg;
        dev_next        = dev_reg;
        pdev_next       = pdev_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        ns_next         = ns_reg;
        kind_next       = kind_reg;

        o_kind_next = o_kind_reg;
        o_ns_next   = o_ns_reg;
        o_sec_next  = o_sec_reg;
        o_lat_next  = o_lat_reg;
        o_lon_next  = o_lon_reg;
        o_alt_next  = o_alt_reg;
        o_busy_next = o_busy_reg;

        div_req = '0;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                pstq_pkg::CFG_MAX_SPS:   max_sps_next  = cfg.data[pstq_pkg::SPS_W-1:0];
                pstq_pkg::CFG_MAX_BUSY:  max_busy_next = cfg.data[pstq_pkg::SPS_W-1:0];
                pstq_pkg::CFG_TIME_TOL:  time_tol_next = cfg.data[pstq_pkg::PPM_W-1:0];
                pstq_pkg::CFG_POS_TOL:   pos_tol_next  = cfg.data[pstq_pkg::TOL_W-1:0];
                pstq_pkg::CFG_HEARTBEAT: hb_next       = cfg.data[pstq_pkg::HB_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.cmd == pstq_pkg::CMD_STRIKE)
                    begin
                        if (strikes_reg != '1)
                            strikes_next = strikes_reg + 1'b1;
                        if (report_ok && !imode_reg)
                        begin
                            mul_a_next = pstq_pkg::NS_SCALE;
                            mul_b_next = dif_val;
                            acc_next   = '0;
                            state_next = ST_S_MUL;
                        end
                    end
                    else
                    begin
                        prev_counter_next = item.counter;
                        if (!primed_reg)
                            primed_next = 1'b1;
                        else
                        begin
                            dif_next     = dif_val;
                            sec_in_next  = item.second;
                            lat_in_next  = item.latitude;
                            lon_in_next  = item.longitude;
                            alt_in_next  = item.altitude;
                            wall_in_next = item.wall_seconds;
                            state_next   = ST_R_SUM;
                        end
                    end
                end
            end

            ST_S_MUL, ST_M_MUL:
            begin
                if (mul_b_reg != '0)
                begin
                    if (mul_b_reg[0])
                        acc_next = acc_reg + mul_a_reg;
                    mul_a_next = {mul_a_reg[pstq_pkg::DIV_W-2:0], 1'b0};
                    mul_b_next = mul_b_reg >> 1;
                end
                else if (state_reg == ST_S_MUL)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = acc_reg;
                    div_req.divisor  = (isum_reg == '0) ? pstq_pkg::DVR_W'(1)
                                                        : pstq_pkg::DVR_W'(isum_reg);
                    neg_next         = 1'b0;
                    state_next       = ST_S_DIV;
                end
                else
                begin
                    // Floor division of a negative value uses ceil of its magnitude.
                    x_val            = acc_reg;
                    neg_next         = x_val[pstq_pkg::DIV_W-1];
                    div_req.start    = 1'b1;
                    div_req.dividend = x_val[pstq_pkg::DIV_W-1]
                                     ? ~x_val + pstq_pkg::DIV_W'(pstq_pkg::SMOOTH_DIVISOR)
                                     : x_val;
                    div_req.divisor  = pstq_pkg::DVR_W'(pstq_pkg::SMOOTH_DIVISOR);
                    state_next       = ST_M_DIV;
                end
            end

            ST_S_DIV:
            begin
                if (div_rsp.done)
                begin
                    ns_next    = (div_rsp.quotient > pstq_pkg::DIV_W'(pstq_pkg::NS_MAX))
                               ? pstq_pkg::NS_MAX : div_rsp.quotient[pstq_pkg::NS_W-1:0];
                    kind_next  = pstq_pkg::KIND_STRIKE;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || report.ready)
                begin
                    out_valid_next = 1'b1;
                    o_kind_next    = kind_reg;
                    o_sec_next     = prev_second_reg;
                    o_lat_next     = clip(round_frac(smooth_reg[0]), pstq_pkg::LAT_W)
                                     [pstq_pkg::LAT_W-1:0];
                    o_lon_next     = clip(round_frac(smooth_reg[1]), pstq_pkg::LON_W)
                                     [pstq_pkg::LON_W-1:0];
                    o_alt_next     = clip(round_frac(smooth_reg[2]), pstq_pkg::ALT_W)
                                     [pstq_pkg::ALT_W-1:0];
                    if (kind_reg == pstq_pkg::KIND_STRIKE)
                    begin
                        o_ns_next        = ns_reg;
                        o_busy_next      = '0;
                        last_report_next = last_wall_reg;
                    end
                    else
                    begin
                        o_ns_next   = '0;
                        o_busy_next = busy_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_R_SUM:
            begin
                sec_ok_next      = (sec_in_reg == sec_expect);
                prev_second_next = sec_in_reg;
                isum_next        = isum_reg - pstq_pkg::ISUM_W'(iv_ring_reg[ptr_reg])
                                 + pstq_pkg::ISUM_W'(dif_reg);
                lat_sum_next     = lat_sum_reg + pstq_pkg::LAT_SUM_W'(lat_in_reg)
                                 - pstq_pkg::LAT_SUM_W'(lat_ring_reg[ptr_reg]);
                lon_sum_next     = lon_sum_reg + pstq_pkg::LON_SUM_W'(lon_in_reg)
                                 - pstq_pkg::LON_SUM_W'(lon_ring_reg[ptr_reg]);
                alt_sum_next     = alt_sum_reg + pstq_pkg::ALT_SUM_W'(alt_in_reg)
                                 - pstq_pkg::ALT_SUM_W'(alt_ring_reg[ptr_reg]);
                iv_ring_next[ptr_reg]  = dif_reg;
                lat_ring_next[ptr_reg] = lat_in_reg;
                lon_ring_next[ptr_reg] = lon_in_reg;
                alt_ring_next[ptr_reg] = alt_in_reg;
                ptr_next = (ptr_reg == pstq_pkg::PTR_W'(pstq_pkg::RING_DEPTH - 1))
                         ? '0 : ptr_reg + 1'b1;
                was_pos_ok_next = pos_ok_reg;
                state_next      = ST_R_DEV;
            end

            ST_R_DEV:
            begin
                dev_next   = (dev_s < 0) ? DEV_W'(-dev_s) : DEV_W'(dev_s);
                pdev_next  = PDEV_W'(lat_abs) + PDEV_W'(lon_abs);
                state_next = ST_R_FLAG;
            end

            ST_R_FLAG:
            begin
                acc_ok_next = (dev_scaled < tol_scaled);
                pos_ok_next = (pdev_reg < PDEV_W'(pos_tol_reg) * PDEV_W'(pstq_pkg::RING_DEPTH));
                busy_next   = busy_inc;
                if ((strikes_reg >= max_sps_reg) || (busy_inc >= max_busy_reg))
                    imode_next = 1'b1;
                if (strikes_reg == '0)
                begin
                    busy_next  = '0;
                    imode_next = 1'b0;
                end
                strikes_next = '0;
                axis_next    = 2'd0;
                state_next   = ST_A_START;
            end

            ST_A_START:
            begin
                // Average with rounding: (sum * 2^16 + N/2) / N, floored.
                x_val = {{(pstq_pkg::DIV_W - pstq_pkg::LON_SUM_W - pstq_pkg::FRAC_BITS)
                          {sum_ax[pstq_pkg::LON_SUM_W-1]}},
                         sum_ax, pstq_pkg::FRAC_BITS'(pstq_pkg::RING_DEPTH / 2)};
                neg_next         = x_val[pstq_pkg::DIV_W-1];
                div_req.start    = 1'b1;
                div_req.dividend = x_val[pstq_pkg::DIV_W-1]
                                 ? ~x_val + pstq_pkg::DIV_W'(pstq_pkg::RING_DEPTH)
                                 : x_val;
                div_req.divisor  = pstq_pkg::DVR_W'(pstq_pkg::RING_DEPTH);
                state_next       = ST_A_DIV;
            end

            ST_A_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (!was_pos_ok_reg && pos_ok_reg)
                    begin
                        smooth_next[axis_reg] = avg_val;
                        if (axis_reg == 2'd2)
                            state_next = ST_HB;
                        else
                        begin
                            axis_next  = axis_reg + 2'd1;
                            state_next = ST_A_START;
                        end
                    end
                    else
                    begin
                        mul_a_next = pstq_pkg::DIV_W'(smooth_reg[axis_reg]);
                        mul_b_next = pstq_pkg::MUL_B_W'(pstq_pkg::SMOOTH_DIVISOR - 1);
                        acc_next   = pstq_pkg::DIV_W'(avg_val)
                                   + pstq_pkg::DIV_W'(pstq_pkg::SMOOTH_DIVISOR / 2);
                        state_next = ST_M_MUL;
                    end
                end
            end

            ST_M_DIV:
            begin
                if (div_rsp.done)
                begin
                    smooth_next[axis_reg] = avg_val;
                    if (axis_reg == 2'd2)
                        state_next = ST_HB;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_A_START;
                    end
                end
            end

            ST_HB:
            begin
                last_wall_next = wall_in_reg;
                if (report_ok && ({1'b0, wall_in_reg} >
                    {1'b0, last_report_reg} + (pstq_pkg::WALL_W + 1)'(hb_reg)))
                begin
                    last_report_next = wall_in_reg;
                    kind_next        = pstq_pkg::KIND_HEARTBEAT;
                    state_next       = ST_EMIT;
                end
                else
                    state_next = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    pstq_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_sps_reg      <= pstq_pkg::RST_MAX_SPS;
            max_busy_reg     <= pstq_pkg::RST_MAX_BUSY;
            time_tol_reg     <= pstq_pkg::RST_TIME_TOL;
            pos_tol_reg      <= pstq_pkg::RST_POS_TOL;
            hb_reg           <= pstq_pkg::RST_HEARTBEAT;
            state_reg        <= ST_IDLE;
            primed_reg       <= 1'b0;
            prev_counter_reg <= '0;
            prev_second_reg  <= '0;
            iv_ring_reg      <= '{default: '0};
            lat_ring_reg     <= '{default: '0};
            lon_ring_reg     <= '{default: '0};
            alt_ring_reg     <= '{default: '0};
            ptr_reg          <= '0;
            isum_reg         <= pstq_pkg::ISUM_W'(1);
            lat_sum_reg      <= '0;
            lon_sum_reg      <= '0;
            alt_sum_reg      <= '0;
            sec_ok_reg       <= 1'b0;
            acc_ok_reg       <= 1'b0;
            pos_ok_reg       <= 1'b0;
            imode_reg        <= 1'b0;
            strikes_reg      <= '0;
            busy_reg         <= '0;
            smooth_reg       <= '{default: '0};
            last_report_reg  <= '0;
            last_wall_reg    <= '0;
            out_valid_reg    <= 1'b0;
            axis_reg         <= '0;
        end
        else
        begin
            max_sps_reg      <= max_sps_next;
            max_busy_reg     <= max_busy_next;
            time_tol_reg     <= time_tol_next;
            pos_tol_reg      <= pos_tol_next;
            hb_reg           <= hb_next;
            state_reg        <= state_next;
            primed_reg       <= primed_next;
            prev_counter_reg <= prev_counter_next;
            prev_second_reg  <= prev_second_next;
            iv_ring_reg      <= iv_ring_next;
            lat_ring_reg     <= lat_ring_next;
            lon_ring_reg     <= lon_ring_next;
            alt_ring_reg     <= alt_ring_next;
            ptr_reg          <= ptr_next;
            isum_reg         <= isum_next;
            lat_sum_reg      <= lat_sum_next;
            lon_sum_reg      <= lon_sum_next;
            alt_sum_reg      <= alt_sum_next;
            sec_ok_reg       <= sec_ok_next;
            acc_ok_reg       <= acc_ok_next;
            pos_ok_reg       <= pos_ok_next;
            imode_reg        <= imode_next;
            strikes_reg      <= strikes_next;
            busy_reg         <= busy_next;
            smooth_reg       <= smooth_next;
            last_report_reg  <= last_report_next;
            last_wall_reg    <= last_wall_next;
            out_valid_reg    <= out_valid_next;
            axis_reg         <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dif_reg        <= dif_next;
        sec_in_reg     <= sec_in_next;
        lat_in_reg     <= lat_in_next;
        lon_in_reg     <= lon_in_next;
        alt_in_reg     <= alt_in_next;
        wall_in_reg    <= wall_in_next;
        was_pos_ok_reg <= was_pos_ok_next;
        dev_reg        <= dev_next;
        pdev_reg       <= pdev_next;
        mul_a_reg      <= mul_a_next;
        mul_b_reg      <= mul_b_next;
        acc_reg        <= acc_next;
        neg_reg        <= neg_next;
        ns_reg         <= ns_next;
        kind_reg       <= kind_next;
        o_kind_reg     <= o_kind_next;
        o_ns_reg       <= o_ns_next;
        o_sec_reg      <= o_sec_next;
        o_lat_reg      <= o_lat_next;
        o_lon_reg      <= o_lon_next;
        o_alt_reg      <= o_alt_next;
        o_busy_reg     <= o_busy_next;
    end

endmodule
